FILE: rtl/core/mrmo_pkg.sv
// shared types and codes for the memory region map overlay block
`timescale 1ns / 1ps

package mrmo_pkg;

   typedef enum logic [1:0] {
      REQ_DEFINE   = 2'd0,
      REQ_COALESCE = 2'd1,
      REQ_LOOKUP   = 2'd2,
      REQ_NONE     = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_BAD  = 2'd2
   } status_code_type;

   localparam int ADDR_BITS  = 64;
   localparam int INDEX_BITS = 6;
   localparam int COUNT_BITS = 7;

endpackage

FILE: rtl/core/mrmo_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mrmo_ram #(
   parameter int WIDTH = 132,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/memory_region_map_overlay_core.sv
// memory region map overlay: region table with define, coalesce and lookup
//
// one request transfers on req_valid/req_ready and yields exactly one
// response on rsp_valid/rsp_ready. req_ready is high only while the
// sequencer is idle; one item is worked on at a time.
// the table is held as base/last/type rows in two ram banks; a define or
// coalesce reads the live bank one row per step and writes the rebuilt
// table into the other bank, which becomes live when the request commits.
// a rejected define leaves the live bank untouched.
// all steps share one ram read port, one write port and one set of compares.
// a finished response waits in an output register; a new request is
// taken once the sequencer has handed its response to that register,
// so a stalled receiver holds back only the following result.
// reset clears the region count, the sequencer and rsp_valid; ram
// contents need no reset since rows past the count are never read.
`timescale 1ns / 1ps

module memory_region_map_overlay_core #(
   parameter int MAX_REGIONS = 64,
   parameter int TYPE_BITS   = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [63:0]          req_region_base,
   input  logic [63:0]          req_region_size,
   input  logic [TYPE_BITS-1:0] req_region_type,
   input  logic [63:0]          req_lookup_addr,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic                 rsp_in_found,
   output logic [5:0]           rsp_in_index,
   output logic                 rsp_after_found,
   output logic [5:0]           rsp_after_index,
   output logic                 rsp_before_found,
   output logic [5:0]           rsp_before_index,
   output logic [6:0]           rsp_region_count
);

   localparam int AW = mrmo_pkg::ADDR_BITS;
   localparam int IW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int NW = $clog2(MAX_REGIONS + 3);
   localparam int DW = 2 * AW + TYPE_BITS;
   localparam logic [AW-1:0] ALL_ONES = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_D_RD, S_D_EV, S_D_OVN, S_D_OVH, S_D_OLD, S_D_FIN,
      S_C_RD0, S_C_LD0, S_C_RD, S_C_EV, S_L_RD, S_L_EV, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic cur_ff, cur_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [NW-1:0] n_ff, n_in;
   logic placed_ff, placed_in;
   logic [AW-1:0] nb_ff, nb_in;
   logic [AW-1:0] nl_ff, nl_in;
   logic [TYPE_BITS-1:0] nt_ff, nt_in;

   logic [1:0] st_ff, st_in;
   logic inf_ff, inf_in, aff_ff, aff_in, bff_ff, bff_in;
   logic [5:0] ini_ff, ini_in, afi_ff, afi_in, bfi_ff, bfi_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic rsp_inf_ff, rsp_inf_in, rsp_aff_ff, rsp_aff_in, rsp_bff_ff, rsp_bff_in;
   logic [5:0] rsp_ini_ff, rsp_ini_in, rsp_afi_ff, rsp_afi_in, rsp_bfi_ff, rsp_bfi_in;
   logic [6:0] rsp_cnt_ff, rsp_cnt_in;

   logic wr_en;
   logic [IW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [DW-1:0] rd_data0, rd_data1, rd_data;
   logic [AW-1:0] rb, rl;
   logic [TYPE_BITS-1:0] rt;
   logic [NW-1:0] nfin;

   mrmo_ram #(.WIDTH(DW), .DEPTH(MAX_REGIONS)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && cur_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[IW-1:0]),
      .rd_data (rd_data0)
   );

   mrmo_ram #(.WIDTH(DW), .DEPTH(MAX_REGIONS)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !cur_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff[IW-1:0]),
      .rd_data (rd_data1)
   );

   assign rd_data = cur_ff ? rd_data1 : rd_data0;
   assign rb = rd_data[DW-1 -: AW];
   assign rl = rd_data[AW+TYPE_BITS-1 -: AW];
   assign rt = rd_data[TYPE_BITS-1:0];
   assign nfin = n_ff + NW'(!placed_ff);

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_in_found     = rsp_inf_ff;
   assign rsp_in_index     = rsp_ini_ff;
   assign rsp_after_found  = rsp_aff_ff;
   assign rsp_after_index  = rsp_afi_ff;
   assign rsp_before_found = rsp_bff_ff;
   assign rsp_before_index = rsp_bfi_ff;
   assign rsp_region_count = rsp_cnt_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      used_in       = used_ff;
      ptr_in        = ptr_ff;
      n_in          = n_ff;
      placed_in     = placed_ff;
      nb_in         = nb_ff;
      nl_in         = nl_ff;
      nt_in         = nt_ff;
      st_in         = st_ff;
      inf_in        = inf_ff;
      aff_in        = aff_ff;
      bff_in        = bff_ff;
      ini_in        = ini_ff;
      afi_in        = afi_ff;
      bfi_in        = bfi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_inf_in    = rsp_inf_ff;
      rsp_aff_in    = rsp_aff_ff;
      rsp_bff_in    = rsp_bff_ff;
      rsp_ini_in    = rsp_ini_ff;
      rsp_afi_in    = rsp_afi_ff;
      rsp_bfi_in    = rsp_bfi_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = n_ff[IW-1:0];
      wr_data       = {nb_ff, nl_ff, nt_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               st_in     = mrmo_pkg::STATUS_OK;
               inf_in    = 1'b0;
               aff_in    = 1'b0;
               bff_in    = 1'b0;
               ini_in    = '0;
               afi_in    = '0;
               bfi_in    = '0;
               ptr_in    = '0;
               n_in      = '0;
               placed_in = 1'b0;
               unique case (mrmo_pkg::req_code_type'(req_type))
                  mrmo_pkg::REQ_DEFINE: begin
                     nb_in = req_region_base;
                     nl_in = req_region_base + req_region_size - 64'd1;
                     nt_in = req_region_type;
                     if (req_region_size == '0 ||
                         (req_region_size - 64'd1) > ~req_region_base) begin
                        st_in    = mrmo_pkg::STATUS_BAD;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_D_RD;
                     end
                  end
                  mrmo_pkg::REQ_COALESCE: begin
                     state_in = (used_ff == '0) ? S_DONE : S_C_RD0;
                  end
                  mrmo_pkg::REQ_LOOKUP: begin
                     nb_in    = req_lookup_addr;
                     state_in = S_L_RD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_D_RD: begin
            state_in = (ptr_ff == used_ff) ? S_D_FIN : S_D_EV;
         end
         S_D_EV: begin
            if (rl < nb_ff) begin
               wr_en    = (n_ff < NW'(MAX_REGIONS));
               wr_data  = rd_data;
               n_in     = n_ff + 1'b1;
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_D_RD;
            end else if (rb > nl_ff) begin
               wr_en = (n_ff < NW'(MAX_REGIONS));
               n_in  = n_ff + 1'b1;
               if (!placed_ff) begin
                  placed_in = 1'b1;
                  state_in  = S_D_OLD;
               end else begin
                  wr_data  = rd_data;
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_D_RD;
               end
            end else begin
               if (rb < nb_ff) begin
                  wr_en   = (n_ff < NW'(MAX_REGIONS));
                  wr_data = {rb, nb_ff - 64'd1, rt};
                  n_in    = n_ff + 1'b1;
               end
               state_in = S_D_OVN;
            end
         end
         S_D_OVN: begin
            if (!placed_ff) begin
               wr_en     = (n_ff < NW'(MAX_REGIONS));
               n_in      = n_ff + 1'b1;
               placed_in = 1'b1;
            end
            state_in = S_D_OVH;
         end
         S_D_OVH: begin
            if (rl > nl_ff) begin
               wr_en   = (n_ff < NW'(MAX_REGIONS));
               wr_data = {nl_ff + 64'd1, rl, rt};
               n_in    = n_ff + 1'b1;
            end
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_D_RD;
         end
         S_D_OLD: begin
            wr_en    = (n_ff < NW'(MAX_REGIONS));
            wr_data  = rd_data;
            n_in     = n_ff + 1'b1;
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_D_RD;
         end
         S_D_FIN: begin
            wr_en = !placed_ff && (n_ff < NW'(MAX_REGIONS));
            if (nfin > NW'(MAX_REGIONS)) begin
               st_in = mrmo_pkg::STATUS_FULL;
            end else begin
               cur_in  = !cur_ff;
               used_in = CW'(nfin);
            end
            state_in = S_DONE;
         end
         S_C_RD0: begin
            state_in = S_C_LD0;
         end
         S_C_LD0: begin
            nb_in    = rb;
            nl_in    = rl;
            nt_in    = rt;
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_C_RD;
         end
         S_C_RD: begin
            if (ptr_ff == used_ff) begin
               wr_en    = 1'b1;
               cur_in   = !cur_ff;
               used_in  = CW'(n_ff + 1'b1);
               state_in = S_DONE;
            end else begin
               state_in = S_C_EV;
            end
         end
         S_C_EV: begin
            if (rt == nt_ff && nl_ff != ALL_ONES && (nl_ff + 64'd1) == rb &&
                !(nb_ff == '0 && rl == ALL_ONES)) begin
               nl_in = rl;
            end else begin
               wr_en = 1'b1;
               n_in  = n_ff + 1'b1;
               nb_in = rb;
               nl_in = rl;
               nt_in = rt;
            end
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_C_RD;
         end
         S_L_RD: begin
            state_in = (ptr_ff == used_ff) ? S_DONE : S_L_EV;
         end
         S_L_EV: begin
            if (!inf_ff && rb <= nb_ff && nb_ff <= rl) begin
               inf_in = 1'b1;
               ini_in = 6'(ptr_ff);
            end
            if (!aff_ff && rb > nb_ff) begin
               aff_in = 1'b1;
               afi_in = 6'(ptr_ff);
            end
            if (rl < nb_ff) begin
               bff_in = 1'b1;
               bfi_in = 6'(ptr_ff);
            end
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_L_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_inf_in    = inf_ff;
               rsp_aff_in    = aff_ff;
               rsp_bff_in    = bff_ff;
               rsp_ini_in    = ini_ff;
               rsp_afi_in    = afi_ff;
               rsp_bfi_in    = bfi_ff;
               rsp_cnt_in    = 7'(used_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      n_ff          <= n_in;
      placed_ff     <= placed_in;
      nb_ff         <= nb_in;
      nl_ff         <= nl_in;
      nt_ff         <= nt_in;
      st_ff         <= st_in;
      inf_ff        <= inf_in;
      aff_ff        <= aff_in;
      bff_ff        <= bff_in;
      ini_ff        <= ini_in;
      afi_ff        <= afi_in;
      bfi_ff        <= bfi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_inf_ff    <= rsp_inf_in;
      rsp_aff_ff    <= rsp_aff_in;
      rsp_bff_ff    <= rsp_bff_in;
      rsp_ini_ff    <= rsp_ini_in;
      rsp_afi_ff    <= rsp_afi_in;
      rsp_bfi_ff    <= rsp_bfi_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_REGIONS))
      else $error("region count above table size");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_D_EV || state_ff == S_C_EV || state_ff == S_L_EV)
      |-> ptr_ff < used_ff)
      else $error("table walk past live rows");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != mrmo_pkg::STATUS_OK
      |-> !rsp_inf_ff && !rsp_aff_ff && !rsp_bff_ff)
      else $error("lookup fields set on rejected define");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_D_FIN && nfin > NW'(MAX_REGIONS)
      |=> cur_ff == $past(cur_ff) && used_ff == $past(used_ff))
      else $error("table changed on full reject");
`endif

endmodule
